FILE: rtl/i2cbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cbb_pkg;

  // Function codes carried by an input beat.
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_WAIT  = 3'd4;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd100;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_ACK_POLL_LIMIT = 1'b0;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_WAIT
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } slot_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_START,
    MODE_STOP,
    MODE_WRITE,
    MODE_READ,
    MODE_RACK,
    MODE_WAIT
  } mode_t;

endpackage

`default_nettype wire

FILE: rtl/i2cbb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2cbb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_front
  import i2cbb_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t in_data,
  output logic          full,
  input  wire logic     slot_pop,
  output slot_t         slot_data,
  output logic          slot_empty
);

  slot_t                  cls;
  logic [$bits(slot_t)-1:0] q_data;

  // A beat without a known command is kept as a plain timing slot.
  always_comb begin
    cls.write_data = in_data.write_data;
    cls.send_ack   = in_data.send_ack;
    cls.sda_sample = in_data.sda_sample;
    cls.cmd        = CMD_NONE;
    if (in_data.cmd_valid) begin
      unique case (in_data.func)
        FUNC_START: cls.cmd = CMD_START;
        FUNC_STOP:  cls.cmd = CMD_STOP;
        FUNC_WRITE: cls.cmd = CMD_WRITE;
        FUNC_READ:  cls.cmd = CMD_READ;
        FUNC_WAIT:  cls.cmd = CMD_WAIT;
        default:    cls.cmd = CMD_NONE;
      endcase
    end
  end

  i2cbb_fifo #(
    .WIDTH($bits(slot_t)),
    .DEPTH(DEPTH)
  ) u_slot_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (slot_pop),
    .rdata (q_data),
    .empty (slot_empty)
  );

  assign slot_data = slot_t'(q_data);

endmodule

`default_nettype wire

FILE: rtl/i2cbb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_back
  import i2cbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire slot_t      slot_data,
  input  wire logic       slot_empty,
  output logic            slot_pop,
  input  wire logic [7:0] ack_poll_limit,
  input  wire logic       res_full,
  output logic            res_push,
  output out_item_t       res_data
);

  mode_t      mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_send_r, ack_send_nxt;
  logic       fail_r, fail_nxt;
  logic [7:0] rx_r, rx_nxt;

  logic       step;
  mode_t      eff_mode;
  logic [1:0] eff_phase;
  logic [3:0] eff_bit;
  logic [7:0] eff_shift;
  logic [7:0] eff_poll;
  logic       eff_scl;
  logic       eff_ack;
  logic       eff_fail;

  mode_t      slot_mode;
  logic       slot_scl;
  logic       slot_sda;
  logic       slot_done;
  logic       slot_fall;
  logic [3:0] bit_inc;
  logic [7:0] shift_in;
  logic [8:0] poll_inc;

  assign step     = !slot_empty && !res_full;
  assign slot_pop = step;
  assign res_push = step;

  // Command launch: an idle sequencer starts the command in the same slot.
  always_comb begin
    eff_mode  = mode_r;
    eff_phase = phase_r;
    eff_bit   = bit_cnt_r;
    eff_shift = shift_r;
    eff_poll  = poll_r;
    eff_scl   = scl_r;
    eff_ack   = ack_send_r;
    eff_fail  = fail_r;
    if (mode_r == MODE_IDLE && slot_data.cmd != CMD_NONE) begin
      eff_phase = '0;
      eff_bit   = '0;
      unique case (slot_data.cmd)
        CMD_START: eff_mode = MODE_START;
        CMD_STOP:  eff_mode = MODE_STOP;
        CMD_WRITE: begin
          eff_mode  = MODE_WRITE;
          eff_shift = slot_data.write_data;
          eff_scl   = 1'b0;
        end
        CMD_READ: begin
          eff_mode  = MODE_READ;
          eff_shift = '0;
          eff_ack   = slot_data.send_ack;
        end
        CMD_WAIT: begin
          eff_mode = MODE_WAIT;
          eff_poll = '0;
          eff_fail = 1'b0;
        end
        default: eff_mode = mode_r;
      endcase
    end
  end

  // Next state for one slot.
  always_comb begin
    bit_inc      = eff_bit + 4'd1;
    shift_in     = {eff_shift[6:0], slot_data.sda_sample};
    poll_inc     = {1'b0, eff_poll} + 9'd1;
    slot_mode    = eff_mode;
    slot_scl     = eff_scl;
    slot_sda     = sda_r;
    slot_done    = 1'b0;
    slot_fall    = 1'b0;
    phase_nxt    = eff_phase;
    bit_cnt_nxt  = eff_bit;
    shift_nxt    = eff_shift;
    poll_nxt     = eff_poll;
    ack_send_nxt = eff_ack;
    fail_nxt     = eff_fail;
    rx_nxt       = rx_r;
    unique case (eff_mode)
      MODE_START: begin
        unique case (eff_phase)
          2'd0: slot_sda = 1'b1;
          2'd1: slot_scl = 1'b1;
          2'd2: slot_sda = 1'b0;
          default: begin
            slot_scl  = 1'b0;
            slot_done = 1'b1;
          end
        endcase
        phase_nxt = eff_phase + 2'd1;
      end
      MODE_STOP: begin
        unique case (eff_phase)
          2'd0: slot_sda = 1'b0;
          2'd1: slot_scl = 1'b1;
          default: begin
            slot_sda  = 1'b1;
            slot_done = 1'b1;
          end
        endcase
        phase_nxt = eff_phase + 2'd1;
      end
      MODE_WRITE: begin
        unique case (eff_phase)
          2'd0: begin
            slot_sda  = eff_shift[7];
            shift_nxt = {eff_shift[6:0], 1'b0};
            phase_nxt = 2'd1;
          end
          2'd1: begin
            slot_scl  = 1'b1;
            phase_nxt = 2'd2;
          end
          default: begin
            slot_scl    = 1'b0;
            phase_nxt   = 2'd0;
            bit_cnt_nxt = bit_inc;
            slot_done   = (bit_inc >= 4'd8);
          end
        endcase
      end
      MODE_READ: begin
        if (eff_phase == 2'd0) begin
          slot_scl  = 1'b0;
          slot_sda  = 1'b1;
          phase_nxt = 2'd1;
        end else begin
          slot_scl    = 1'b1;
          shift_nxt   = shift_in;
          bit_cnt_nxt = bit_inc;
          phase_nxt   = 2'd0;
          if (bit_inc >= 4'd8) begin
            rx_nxt    = shift_in;
            slot_mode = MODE_RACK;
          end
        end
      end
      MODE_RACK: begin
        if (eff_phase == 2'd0) begin
          slot_scl  = 1'b0;
          slot_sda  = !eff_ack;
          phase_nxt = 2'd1;
        end else begin
          slot_scl  = 1'b1;
          slot_done = 1'b1;
          slot_fall = 1'b1;
        end
      end
      MODE_WAIT: begin
        slot_scl = 1'b1;
        if (!slot_data.sda_sample) begin
          slot_done = 1'b1;
          slot_fall = 1'b1;
        end else begin
          poll_nxt = poll_inc[8] ? 8'hFF : poll_inc[7:0];
          if (poll_inc > {1'b0, ack_poll_limit}) begin
            fail_nxt  = 1'b1;
            slot_mode = MODE_STOP;
            phase_nxt = 2'd0;
          end
        end
      end
      default: slot_mode = MODE_IDLE;
    endcase
    mode_nxt = slot_mode;
    scl_nxt  = slot_scl && !slot_fall;
    sda_nxt  = slot_sda;
    if (slot_done) begin
      mode_nxt    = MODE_IDLE;
      phase_nxt   = '0;
      bit_cnt_nxt = '0;
    end
  end

  always_comb begin
    res_data.scl_level  = slot_scl;
    res_data.sda_level  = slot_sda;
    res_data.busy_res   = (slot_mode != MODE_IDLE) && !slot_done;
    res_data.done_res   = slot_done;
    res_data.read_data  = rx_nxt;
    res_data.ack_failed = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      phase_r    <= '0;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      poll_r     <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_send_r <= 1'b0;
      fail_r     <= 1'b0;
      rx_r       <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      poll_r     <= poll_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_send_r <= ack_send_nxt;
      fail_r     <= fail_nxt;
      rx_r       <= rx_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !(res_data.busy_res && res_data.done_res))
    else $error("busy and done reported in the same slot");

  a_plain_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode_r == MODE_IDLE && slot_data.cmd == CMD_NONE) |=> mode_r == MODE_IDLE)
    else $error("plain slot left the sequencer idle state");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter ran past one byte");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mode_r) && $stable(phase_r) && $stable(scl_r))
    else $error("sequencer state moved without a slot");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_START |-> phase_r != 2'd3)
    else $error("fourth phase reached outside a start command");
`endif

endmodule

`default_nettype wire

FILE: rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Path: input queue (registered), back end (combinational), result queue (registered).
// Throughput: the back end retires one line slot per cycle while the result queue has room.
// Input and result queues of MID_DEPTH and OUT_DEPTH entries decouple the two sides.
// Reset is synchronous and active low: queues empty, sequencer idle, SCL and SDA high,
// and the ACK poll limit returns to 100.

module i2c_master_bit_sequencer
  import i2cbb_pkg::*;
#(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire in_item_t              in_data,
  output logic                       full,
  output out_item_t                  out_data,
  output logic                       empty,
  input  wire logic                  pop,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [7:0] poll_limit_r;
  logic       cfg_wr;
  logic       reg_hit;

  slot_t      slot_data;
  logic       slot_empty;
  logic       slot_pop;
  logic       res_full;
  logic       res_push;
  out_item_t  res_data;
  logic [$bits(out_item_t)-1:0] out_q;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_ACK_POLL_LIMIT);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? {24'd0, poll_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_wr) begin
      poll_limit_r <= pwdata[7:0];
    end
  end

  i2cbb_front #(
    .DEPTH(MID_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .slot_pop   (slot_pop),
    .slot_data  (slot_data),
    .slot_empty (slot_empty)
  );

  i2cbb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .slot_data      (slot_data),
    .slot_empty     (slot_empty),
    .slot_pop       (slot_pop),
    .ack_poll_limit (poll_limit_r),
    .res_full       (res_full),
    .res_push       (res_push),
    .res_data       (res_data)
  );

  i2cbb_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_q),
    .empty (empty)
  );

  assign out_data = out_item_t'(out_q);

endmodule

`default_nettype wire

FILE: verif/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_tb;
  import i2cbb_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * REG_ACK_POLL_LIMIT);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  in_item_t              in_data = '0;
  logic                  full;
  out_item_t             out_data;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  in_item_t  pending_slots[$];
  out_item_t expected_lines[$];
  int        err_cnt = 0;
  logic      hold_kick = 1'b0;

  // Line sequencer state as seen from outside.
  mode_t      seq_mode;
  logic [1:0] seq_phase;
  logic [3:0] seq_bits;
  logic [7:0] seq_shift;
  logic [7:0] seq_polls;
  logic       seq_scl;
  logic       seq_sda;
  logic       seq_ack;
  logic       seq_fail;
  logic [7:0] seq_rx;
  logic [7:0] poll_limit;

  i2c_master_bit_sequencer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .out_data(out_data),
    .empty   (empty),
    .pop     (pop),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_item_t sequence_slot(in_item_t it);
    out_item_t  r;
    logic       fin;
    logic       scl_drop;
    logic [8:0] polls_next;
    fin = 1'b0;
    scl_drop = 1'b0;
    if (seq_mode == MODE_IDLE && it.cmd_valid && it.func <= FUNC_WAIT) begin
      seq_phase = '0;
      seq_bits = '0;
      case (it.func)
        FUNC_START: seq_mode = MODE_START;
        FUNC_STOP: seq_mode = MODE_STOP;
        FUNC_WRITE: begin
          seq_mode = MODE_WRITE;
          seq_shift = it.write_data;
          seq_scl = 1'b0;
        end
        FUNC_READ: begin
          seq_mode = MODE_READ;
          seq_shift = '0;
          seq_ack = it.send_ack;
        end
        default: begin
          seq_mode = MODE_WAIT;
          seq_polls = '0;
          seq_fail = 1'b0;
        end
      endcase
    end
    case (seq_mode)
      MODE_START: begin
        case (seq_phase)
          2'd0: seq_sda = 1'b1;
          2'd1: seq_scl = 1'b1;
          2'd2: seq_sda = 1'b0;
          default: begin
            seq_scl = 1'b0;
            fin = 1'b1;
          end
        endcase
        seq_phase = seq_phase + 2'd1;
      end
      MODE_STOP: begin
        case (seq_phase)
          2'd0: seq_sda = 1'b0;
          2'd1: seq_scl = 1'b1;
          default: begin
            seq_sda = 1'b1;
            fin = 1'b1;
          end
        endcase
        seq_phase = seq_phase + 2'd1;
      end
      MODE_WRITE: begin
        if (seq_phase == 2'd0) begin
          seq_sda = seq_shift[7];
          seq_shift = seq_shift << 1;
          seq_phase = 2'd1;
        end else if (seq_phase == 2'd1) begin
          seq_scl = 1'b1;
          seq_phase = 2'd2;
        end else begin
          seq_scl = 1'b0;
          seq_phase = 2'd0;
          seq_bits = seq_bits + 4'd1;
          if (seq_bits >= 4'd8) fin = 1'b1;
        end
      end
      MODE_READ: begin
        if (seq_phase == 2'd0) begin
          seq_scl = 1'b0;
          seq_sda = 1'b1;
          seq_phase = 2'd1;
        end else begin
          seq_scl = 1'b1;
          seq_shift = {seq_shift[6:0], it.sda_sample};
          seq_bits = seq_bits + 4'd1;
          seq_phase = 2'd0;
          if (seq_bits >= 4'd8) begin
            seq_rx = seq_shift;
            seq_mode = MODE_RACK;
          end
        end
      end
      MODE_RACK: begin
        if (seq_phase == 2'd0) begin
          seq_scl = 1'b0;
          seq_sda = !seq_ack;
          seq_phase = 2'd1;
        end else begin
          seq_scl = 1'b1;
          fin = 1'b1;
          scl_drop = 1'b1;
        end
      end
      MODE_WAIT: begin
        seq_scl = 1'b1;
        if (!it.sda_sample) begin
          fin = 1'b1;
          scl_drop = 1'b1;
        end else begin
          // The compare is one bit wider, so a limit of 255 allows 255 high polls.
          polls_next = {1'b0, seq_polls} + 9'd1;
          seq_polls = polls_next[8] ? 8'hFF : polls_next[7:0];
          if (polls_next > {1'b0, poll_limit}) begin
            seq_fail = 1'b1;
            seq_mode = MODE_STOP;
            seq_phase = '0;
          end
        end
      end
      default: seq_mode = MODE_IDLE;
    endcase
    r.scl_level = seq_scl;
    r.sda_level = seq_sda;
    r.busy_res = (seq_mode != MODE_IDLE) && !fin;
    r.done_res = fin;
    r.read_data = seq_rx;
    r.ack_failed = seq_fail;
    if (fin) begin
      seq_mode = MODE_IDLE;
      seq_phase = '0;
      seq_bits = '0;
    end
    if (scl_drop) seq_scl = 1'b0;
    return r;
  endfunction

  function automatic string line_str(out_item_t r);
    return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b rd=%02h fail=%0b", r.scl_level,
                     r.sda_level, r.busy_res, r.done_res, r.read_data, r.ack_failed);
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Driver.
  int       in_gap = 0;
  bit       in_steady = 1'b0;
  in_item_t cur_slot;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_gap = 0;
      seq_mode = MODE_IDLE;
      seq_phase = '0;
      seq_bits = '0;
      seq_shift = '0;
      seq_polls = '0;
      seq_scl = 1'b1;
      seq_sda = 1'b1;
      seq_ack = 1'b0;
      seq_fail = 1'b0;
      seq_rx = '0;
      poll_limit = POLL_LIMIT_RESET;
    end else begin
      if (push && !full) begin
        cur_slot = pending_slots.pop_front();
        expected_lines.push_back(sequence_slot(cur_slot));
        in_gap = in_steady ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
      end
      if (!(push && full)) begin
        if (in_gap > 0) begin
          in_gap--;
          push <= 1'b0;
        end else if (pending_slots.size() > 0) begin
          push <= 1'b1;
          in_data <= pending_slots[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  int        out_gap = 0;
  bit        out_steady = 1'b0;
  bit        hold_taken = 1'b0;
  out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      out_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_lines.size() == 0) begin
          note_error($sformatf("unexpected beat: %s", line_str(out_data)));
        end else begin
          want = expected_lines.pop_front();
          if (out_data.scl_level !== want.scl_level || out_data.sda_level !== want.sda_level ||
              out_data.busy_res !== want.busy_res || out_data.done_res !== want.done_res ||
              out_data.read_data !== want.read_data ||
              out_data.ack_failed !== want.ack_failed) begin
            note_error($sformatf("mismatch: expected %s, got %s", line_str(want),
                                 line_str(out_data)));
          end
        end
        out_gap = out_steady ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
      end
      if (hold_kick && !hold_taken) begin
        hold_taken = 1'b1;
        out_gap = 300;
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic bit rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] rfunc();
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic add_slot(bit cv, logic [2:0] fn, logic [7:0] wd, bit sa, bit sd);
    in_item_t s;
    s.cmd_valid = cv;
    s.func = fn;
    s.write_data = wd;
    s.send_ack = sa;
    s.sda_sample = sd;
    pending_slots.push_back(s);
  endtask

  // Slots while a command runs carry random commands, which must be ignored.
  task automatic add_busy(int n);
    repeat (n) add_slot(rbit(), rfunc(), rbyte(), rbit(), rbit());
  endtask

  task automatic add_idle(int n, bit sd);
    repeat (n) add_slot(1'b0, rfunc(), rbyte(), rbit(), sd);
  endtask

  task automatic add_gap();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 3) == 0)
        add_slot(1'b1, 3'($urandom_range(int'(FUNC_WAIT) + 1, 7)), rbyte(), rbit(), rbit());
      else
        add_idle(1, rbit());
    end
  endtask

  task automatic do_start();
    add_slot(1'b1, FUNC_START, rbyte(), rbit(), rbit());
    add_busy(3);
  endtask

  task automatic do_stop();
    add_slot(1'b1, FUNC_STOP, rbyte(), rbit(), rbit());
    add_busy(2);
  endtask

  task automatic do_write(logic [7:0] b);
    add_slot(1'b1, FUNC_WRITE, b, rbit(), rbit());
    add_busy(23);
  endtask

  task automatic do_read(bit ack);
    add_slot(1'b1, FUNC_READ, rbyte(), ack, rbit());
    add_busy(17);
  endtask

  task automatic do_wait(int highs, bit timeout);
    int n;
    n = timeout ? int'(poll_limit) + 1 : highs + 1;
    for (int i = 0; i < n; i++) begin
      if (i == 0) add_slot(1'b1, FUNC_WAIT, rbyte(), rbit(), timeout || highs > 0);
      else add_slot(rbit(), rfunc(), rbyte(), rbit(), timeout || i < highs);
    end
    if (timeout) add_busy(3);
  endtask

  task automatic add_ack_wait();
    if (poll_limit <= 8'd8 && $urandom_range(0, 5) == 0)
      do_wait(0, 1'b1);
    else
      do_wait($urandom_range(0, poll_limit < 8'd5 ? int'(poll_limit) : 5), 1'b0);
  endtask

  task automatic add_transfer();
    int n;
    n = $urandom_range(1, 3);
    do_start();
    add_gap();
    do_write(rbyte());
    add_gap();
    add_ack_wait();
    add_gap();
    if (rbit()) begin
      repeat (n) begin
        do_write(rbyte());
        add_gap();
        add_ack_wait();
        add_gap();
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        do_read(i < n - 1 ? 1'b1 : rbit());
        add_gap();
      end
    end
    do_stop();
    add_gap();
  endtask

  task automatic add_broken();
    case ($urandom_range(0, 2))
      0: begin
        do_start();
        do_stop();
      end
      1: do_write(rbyte());
      default: begin
        do_read(rbit());
        add_ack_wait();
      end
    endcase
    add_gap();
  endtask

  task automatic add_noise();
    repeat ($urandom_range(4, 16)) add_slot(rbit(), rfunc(), rbyte(), rbit(), rbit());
  endtask

  task automatic drain();
    while (pending_slots.size() != 0 || push || expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic read_poll_limit(logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, v})
      note_error($sformatf("poll limit reads %08h, expected %02h", prdata, v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_poll_limit(logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    poll_limit = v;
    read_poll_limit(v);
  endtask

  initial begin
    logic [7:0] limits [5];
    int         pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_poll_limit(POLL_LIMIT_RESET);

    add_idle(2, 1'b1);
    add_slot(1'b1, FUNC_WAIT + 3'd1, rbyte(), rbit(), rbit());
    add_slot(1'b1, FUNC_WAIT + 3'd3, rbyte(), rbit(), rbit());
    do_start();
    do_write(8'hFF);
    do_wait(0, 1'b0);
    do_write(8'h00);
    do_wait(1, 1'b0);
    do_read(1'b1);
    do_read(1'b0);
    do_wait(0, 1'b1);
    do_wait(2, 1'b0);
    do_stop();
    add_idle(8, 1'b0);
    drain();

    limits = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd3};
    limits[3] = 8'($urandom_range(2, 254));
    for (int p = 0; p < 5; p++) begin
      set_poll_limit(limits[p]);
      if (p == 2) hold_kick <= 1'b1;
      if (limits[p] == 8'hFF) do_wait(0, 1'b1);
      while (pending_slots.size() < 64) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) add_transfer();
        else if (pick < 17) add_broken();
        else add_noise();
      end
      add_idle(8, 1'b0);
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_lines.size() != 0)
      note_error($sformatf("%0d beats never arrived", expected_lines.size()));
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
